### hw/rtl/clt_pkg.sv
// Package for the command line tokenizer: character codes, quote modes and step logic.
package clt_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic DIALECT_POSIX   = 1'b0;
	localparam logic DIALECT_WINDOWS = 1'b1;

	typedef enum logic [1:0] {
		QM_NONE   = 2'd0,
		QM_SINGLE = 2'd1,
		QM_DOUBLE = 2'd2
	} quote_t;

	// Tokenizer state carried from one character to the next.
	typedef struct packed {
		quote_t     quote_mode;
		logic       in_argument;
		logic       held_backslash;
	} tok_state_t;

	// Outcome of one character handled with no backslash pending.
	typedef struct packed {
		tok_state_t st;
		logic       emit;
		logic [7:0] ch;
		logic       ended;
	} plain_t;

	// One result item.
	typedef struct packed {
		logic [7:0] first_char;
		logic       first_valid;
		logic [7:0] second_char;
		logic       second_valid;
		logic       arg_end;
		logic       line_done;
	} tok_result_t;

	// Plain character rules; at most one character joins the argument.
	function automatic plain_t plain_step(tok_state_t st, logic dia, logic [7:0] v);
		plain_t r;
		r.st    = st;
		r.emit  = 1'b0;
		r.ch    = v;
		r.ended = 1'b0;
		if (!st.in_argument && (v == CH_SPACE || v == CH_TAB)) begin
			// skip blanks between arguments
		end else begin
			r.st.in_argument = 1'b1;
			if (dia == DIALECT_WINDOWS) begin
				if (v == CH_SPACE && st.quote_mode == QM_NONE) begin
					r.ended          = 1'b1;
					r.st.in_argument = 1'b0;
				end else if (v == CH_BSLASH) begin
					r.st.held_backslash = 1'b1;
				end else if (v == CH_DQUOTE) begin
					r.st.quote_mode = (st.quote_mode != QM_NONE) ? QM_NONE : QM_DOUBLE;
				end else begin
					r.emit = 1'b1;
				end
			end else if (st.quote_mode == QM_SINGLE) begin
				if (v == CH_BSLASH) begin
					r.st.held_backslash = 1'b1;
				end else if (v == CH_SQUOTE) begin
					r.st.quote_mode = QM_NONE;
				end else begin
					r.emit = 1'b1;
				end
			end else if (st.quote_mode != QM_NONE) begin
				if (v == CH_BSLASH) begin
					r.st.held_backslash = 1'b1;
				end else if (v == CH_DQUOTE) begin
					r.st.quote_mode = QM_NONE;
				end else begin
					r.emit = 1'b1;
				end
			end else begin
				if (v == CH_SPACE) begin
					r.ended          = 1'b1;
					r.st.in_argument = 1'b0;
				end else if (v == CH_BSLASH) begin
					r.st.held_backslash = 1'b1;
				end else if (v == CH_DQUOTE) begin
					r.st.quote_mode = QM_DOUBLE;
				end else if (v == CH_SQUOTE) begin
					r.st.quote_mode = QM_SINGLE;
				end else begin
					r.emit = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/command_line_tokenizer_unit.sv
// Command line tokenizer: splits a character stream into arguments, one character per transfer.
// An input transfer reaches the result through the input register and then the result register.
// Throughput: 1 item per cycle while out_stall is low; the tokenizer state updates as an item moves forward.
// While a finished result waits under out_stall, the input register can still take an item, then in_stall rises.
// Reset (arst_n low, asynchronous): both stages empty, not in quotes, no argument, no backslash held,
// dialect back to POSIX rules.
module command_line_tokenizer_unit
	import clt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       dialect,
	// input item channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       line_end,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] first_char,
	output logic       first_valid,
	output logic [7:0] second_char,
	output logic       second_valid,
	output logic       arg_end,
	output logic       line_done
);

	logic        dialect_q;
	tok_state_t  state_q;

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        end_s1;

	// result register
	logic        valid_s2;
	tok_result_t res_s2;

	logic        adv_s2;
	logic        adv_s1;
	tok_state_t  state_d;
	tok_result_t res_d;
	plain_t      pl;

	// The register is only to be written while idle; the block does not enforce this, so it is always ready.
	assign cfg_ready = 1'b1;

	// Result stage takes new data when empty or when its result is being taken.
	assign adv_s2   = !valid_s2 || !out_stall;
	// The input stage moves on whenever the result stage takes it.
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	// Step logic: handle the held item against the current tokenizer state.
	always_comb begin
		state_d = state_q;
		res_d   = '0;
		pl      = plain_step(state_q, dialect_q, char_s1);
		if (end_s1) begin
			// flush: a held backslash joins as itself, an open argument ends
			res_d.first_valid = state_q.held_backslash;
			res_d.first_char  = state_q.held_backslash ? CH_BSLASH : 8'h00;
			res_d.arg_end     = state_q.in_argument || state_q.held_backslash;
			res_d.line_done   = 1'b1;
			state_d.quote_mode     = QM_NONE;
			state_d.in_argument    = 1'b0;
			state_d.held_backslash = 1'b0;
		end else if (state_q.held_backslash) begin
			state_d.held_backslash = 1'b0;
			state_d.in_argument    = 1'b1;
			// rules for a character after a backslash may pass it on to the plain rules
			pl = plain_step(state_d, dialect_q, char_s1);
			if (dialect_q == DIALECT_WINDOWS) begin
				if (char_s1 == CH_DQUOTE) begin
					res_d.first_valid = 1'b1;
					res_d.first_char  = char_s1;
				end else begin
					res_d.first_valid  = 1'b1;
					res_d.first_char   = CH_BSLASH;
					res_d.second_valid = pl.emit;
					res_d.second_char  = pl.emit ? pl.ch : 8'h00;
					res_d.arg_end      = pl.ended;
					state_d            = pl.st;
				end
			end else if (state_q.quote_mode == QM_SINGLE) begin
				// doubled backslash collapses to one
				res_d.first_valid = 1'b1;
				res_d.first_char  = CH_BSLASH;
				if (char_s1 != CH_BSLASH) begin
					res_d.second_valid = pl.emit;
					res_d.second_char  = pl.emit ? pl.ch : 8'h00;
					res_d.arg_end      = pl.ended;
					state_d            = pl.st;
				end
			end else if (state_q.quote_mode != QM_NONE) begin
				if (char_s1 == CH_SQUOTE) begin
					// kept before a single quote inside double quotes
					res_d.first_valid  = 1'b1;
					res_d.first_char   = CH_BSLASH;
					res_d.second_valid = pl.emit;
					res_d.second_char  = pl.emit ? pl.ch : 8'h00;
					res_d.arg_end      = pl.ended;
					state_d            = pl.st;
				end else begin
					res_d.first_valid = 1'b1;
					res_d.first_char  = char_s1;
				end
			end else begin
				res_d.first_valid = 1'b1;
				res_d.first_char  = char_s1;
			end
		end else begin
			res_d.first_valid = pl.emit;
			res_d.first_char  = pl.emit ? pl.ch : 8'h00;
			res_d.arg_end     = pl.ended;
			state_d           = pl.st;
		end
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dialect_q <= DIALECT_POSIX;
			state_q   <= '{quote_mode: QM_NONE, in_argument: 1'b0, held_backslash: 1'b0};
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dialect_q <= dialect;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			// advance the tokenizer state exactly once per item
			if (adv_s1) begin
				state_q <= state_d;
			end
		end
	end

	// Payload registers: hold while stalled.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			end_s1  <= line_end;
		end
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid    = valid_s2;
	assign first_char   = res_s2.first_char;
	assign first_valid  = res_s2.first_valid;
	assign second_char  = res_s2.second_char;
	assign second_valid = res_s2.second_valid;
	assign arg_end      = res_s2.arg_end;
	assign line_done    = res_s2.line_done;

endmodule

### dv/clt_token_monitor.sv
// Token monitor: tracks tokenizer state from observed transfers and checks every result.
`timescale 1ns / 100ps
module clt_token_monitor
	import clt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       dialect,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       line_end,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] first_char,
	input  logic       first_valid,
	input  logic [7:0] second_char,
	input  logic       second_valid,
	input  logic       arg_end,
	input  logic       line_done,
	output int         fail_count,
	output int         tokens_pending
);

	logic        win_rules;
	quote_t      quoting;
	logic        arg_open;
	logic        bs_held;
	logic [7:0]  added [2];
	int          n_added;
	logic        arg_closed;
	tok_result_t token_queue [$];
	tok_result_t want;
	int          n_fail = 0;
	int          n_pending = 0;

	assign fail_count     = n_fail;
	assign tokens_pending = n_pending;

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
		$display("ERROR %0t: %s got %h expected %h", $time, what, got, exp);
		n_fail++;
	endtask

	function automatic void add_char(logic [7:0] c);
		if (n_added < 2) begin
			added[n_added] = c;
			n_added++;
		end
	endfunction

	// Character with no backslash pending.
	function automatic void split_plain(logic [7:0] v);
		if (!arg_open) begin
			if (v == CH_SPACE || v == CH_TAB)
				return;
			arg_open = 1'b1;
		end
		if (win_rules == DIALECT_WINDOWS) begin
			if (v == CH_SPACE && quoting == QM_NONE) begin
				arg_closed = 1'b1;
				arg_open   = 1'b0;
			end else if (v == CH_BSLASH) begin
				bs_held = 1'b1;
			end else if (v == CH_DQUOTE) begin
				quoting = (quoting != QM_NONE) ? QM_NONE : QM_DOUBLE;
			end else begin
				add_char(v);
			end
		end else if (quoting == QM_SINGLE) begin
			if (v == CH_BSLASH)
				bs_held = 1'b1;
			else if (v == CH_SQUOTE)
				quoting = QM_NONE;
			else
				add_char(v);
		end else if (quoting != QM_NONE) begin
			if (v == CH_BSLASH)
				bs_held = 1'b1;
			else if (v == CH_DQUOTE)
				quoting = QM_NONE;
			else
				add_char(v);
		end else begin
			if (v == CH_SPACE) begin
				arg_closed = 1'b1;
				arg_open   = 1'b0;
			end else if (v == CH_BSLASH) begin
				bs_held = 1'b1;
			end else if (v == CH_DQUOTE) begin
				quoting = QM_DOUBLE;
			end else if (v == CH_SQUOTE) begin
				quoting = QM_SINGLE;
			end else begin
				add_char(v);
			end
		end
	endfunction

	// Character that settles a held backslash.
	function automatic void split_escaped(logic [7:0] v);
		bs_held  = 1'b0;
		arg_open = 1'b1;
		if (win_rules == DIALECT_WINDOWS) begin
			if (v == CH_DQUOTE) begin
				add_char(v);
			end else begin
				add_char(CH_BSLASH);
				split_plain(v);
			end
		end else if (quoting == QM_SINGLE) begin
			add_char(CH_BSLASH);
			if (v != CH_BSLASH)
				split_plain(v);
		end else if (quoting != QM_NONE) begin
			if (v == CH_SQUOTE) begin
				add_char(CH_BSLASH);
				split_plain(v);
			end else begin
				add_char(v);
			end
		end else begin
			add_char(v);
		end
	endfunction

	function automatic tok_result_t tokenize_char(logic [7:0] v, logic at_end);
		tok_result_t r;
		n_added    = 0;
		added[0]   = 8'h00;
		added[1]   = 8'h00;
		arg_closed = 1'b0;
		if (at_end) begin
			if (bs_held)
				add_char(CH_BSLASH);
			if (arg_open || bs_held)
				arg_closed = 1'b1;
			quoting  = QM_NONE;
			arg_open = 1'b0;
			bs_held  = 1'b0;
		end else if (bs_held) begin
			split_escaped(v);
		end else begin
			split_plain(v);
		end
		r.first_char   = added[0];
		r.first_valid  = (n_added >= 1);
		r.second_char  = added[1];
		r.second_valid = (n_added >= 2);
		r.arg_end      = arg_closed;
		r.line_done    = at_end;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_rules = DIALECT_POSIX;
			quoting   = QM_NONE;
			arg_open  = 1'b0;
			bs_held   = 1'b0;
			token_queue.delete();
			n_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				win_rules = dialect;
			if (in_valid && !in_stall)
				token_queue.insert(token_queue.size(), tokenize_char(char_in, line_end));
			if (out_valid && !out_stall) begin
				if (token_queue.size() == 0) begin
					report_mismatch("result with nothing pending, first_char", first_char, 8'h00);
				end else begin
					want = token_queue.pop_front();
					if (first_char !== want.first_char)
						report_mismatch("first_char", first_char, want.first_char);
					if (first_valid !== want.first_valid)
						report_mismatch("first_valid", 8'(first_valid), 8'(want.first_valid));
					if (second_char !== want.second_char)
						report_mismatch("second_char", second_char, want.second_char);
					if (second_valid !== want.second_valid)
						report_mismatch("second_valid", 8'(second_valid),
							8'(want.second_valid));
					if (arg_end !== want.arg_end)
						report_mismatch("arg_end", 8'(arg_end), 8'(want.arg_end));
					if (line_done !== want.line_done)
						report_mismatch("line_done", 8'(line_done), 8'(want.line_done));
				end
			end
			n_pending = token_queue.size();
		end
	end

endmodule

### dv/tb.sv
// Testbench top for the command line tokenizer: stimulus, dialect writes and the verdict.
`timescale 1ns / 100ps
module tb;
	import clt_pkg::*;

	// End-of-line marker in the scripts below: bit 8 set, character ignored.
	localparam logic [8:0] EOL = 9'h100;

	// Script entries for the special characters, bit 8 clear.
	localparam logic [8:0] SC_TAB    = {1'b0, CH_TAB};
	localparam logic [8:0] SC_SPACE  = {1'b0, CH_SPACE};
	localparam logic [8:0] SC_DQUOTE = {1'b0, CH_DQUOTE};
	localparam logic [8:0] SC_SQUOTE = {1'b0, CH_SQUOTE};
	localparam logic [8:0] SC_BSLASH = {1'b0, CH_BSLASH};

	// POSIX walk-through: blanks between arguments, zero and all-ones bytes, escaped space,
	// single quotes with doubled and lone backslash, double quotes with backslash before a
	// single and a double quote, tab inside an argument, empty quotes, a lone held backslash
	// flushed by end of line. It leaves the line open inside single quotes on purpose.
	localparam logic [8:0] POSIX_SCRIPT [26] = '{
		SC_TAB, SC_SPACE, 9'h000, 9'h0FF, SC_BSLASH, SC_SPACE,
		SC_SQUOTE, SC_BSLASH, SC_BSLASH, SC_BSLASH, 9'h061, SC_SQUOTE,
		SC_DQUOTE, SC_BSLASH, SC_SQUOTE, SC_BSLASH, SC_DQUOTE, SC_DQUOTE,
		SC_TAB, SC_SPACE, SC_DQUOTE, SC_DQUOTE, EOL, SC_BSLASH, EOL, SC_SQUOTE
	};

	// Windows walk-through, entered mid-line from single quotes: the first double quote
	// leaves quoting, then escaped and kept backslashes, a quoted space, empty quotes,
	// end of line inside quotes and a held backslash at end of line.
	localparam logic [8:0] WIN_SCRIPT [19] = '{
		SC_DQUOTE, SC_BSLASH, SC_DQUOTE, SC_BSLASH, 9'h061, SC_DQUOTE, SC_SPACE,
		SC_SQUOTE, SC_DQUOTE, SC_SPACE, SC_DQUOTE, SC_DQUOTE, SC_SPACE, SC_TAB,
		SC_DQUOTE, 9'h062, EOL, SC_BSLASH, EOL
	};

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 108;
	localparam int HOLD_OFF_CYCLES = 40;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_valid   = 1'b0;
	logic       cfg_dialect = DIALECT_POSIX;
	logic       in_valid    = 1'b0;
	logic [7:0] char_in     = 8'h00;
	logic       line_end    = 1'b0;
	logic       out_stall   = 1'b0;

	logic       cfg_ready;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] first_char;
	logic       first_valid;
	logic [7:0] second_char;
	logic       second_valid;
	logic       arg_end;
	logic       line_done;
	int         fail_count;
	int         tokens_pending;

	// Shared knobs: random idling on both sides, and a one-shot long hold-off request.
	bit idle_on      = 1'b1;
	bit hold_off_req = 1'b0;

	always #10 clk = ~clk;

	command_line_tokenizer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.dialect      (cfg_dialect),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_in      (char_in),
		.line_end     (line_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_char   (first_char),
		.first_valid  (first_valid),
		.second_char  (second_char),
		.second_valid (second_valid),
		.arg_end      (arg_end),
		.line_done    (line_done)
	);

	clt_token_monitor token_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.dialect        (cfg_dialect),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_in        (char_in),
		.line_end       (line_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.first_char     (first_char),
		.first_valid    (first_valid),
		.second_char    (second_char),
		.second_valid   (second_valid),
		.arg_end        (arg_end),
		.line_done      (line_done),
		.fail_count     (fail_count),
		.tokens_pending (tokens_pending)
	);

	// Offer one character and hold it until the transfer. An optional idle burst goes
	// first; in this task valid drops only in that burst, never in the step it rises.
	task automatic send_item(logic [7:0] c, logic le);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= c;
		line_end <= le;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering and let every pending result come out. Poll on the falling edge so
	// the count from the monitor is settled; the cycle bound keeps a hung block finite.
	task automatic wait_idle();
		int n;
		in_valid <= 1'b0;
		n = 0;
		do begin
			@(negedge clk);
			n++;
		end while (tokens_pending != 0 && n < 2000);
		repeat (3) @(posedge clk);
	endtask

	// Dialect writes only go in with the pipe empty.
	task automatic write_dialect(logic d);
		wait_idle();
		cfg_dialect <= d;
		cfg_valid   <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Weighted random character: mostly letters and the special characters so that
	// quoting and escapes get deep, with raw bytes for full bit coverage and an
	// occasional end of line (char_in then random, it is ignored).
	task automatic send_random();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			send_item(8'($urandom_range(0, 255)), 1'b1);
		else if (pick < 14)
			send_item(CH_SPACE, 1'b0);
		else if (pick < 18)
			send_item(CH_TAB, 1'b0);
		else if (pick < 26)
			send_item(CH_DQUOTE, 1'b0);
		else if (pick < 33)
			send_item(CH_SQUOTE, 1'b0);
		else if (pick < 43)
			send_item(CH_BSLASH, 1'b0);
		else if (pick < 75)
			send_item(8'(8'h61 + $urandom_range(0, 25)), 1'b0); // lower-case letter
		else
			send_item(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Result side: random stall bursts, plus one long hold-off on request. The hold-off is
	// counted here while the sender keeps offering, so both stages fill and in_stall rises.
	initial begin : result_sink
		int held;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				for (held = 0; held < HOLD_OFF_CYCLES; held++)
					@(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends a hung run with a failure verdict.
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int i;
		int ph;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The POSIX script ends inside single quotes, so the switch to
		// Windows rules lands mid-line with quote state kept.
		write_dialect(DIALECT_POSIX);
		for (i = 0; i < $size(POSIX_SCRIPT); i++)
			send_item(POSIX_SCRIPT[i][7:0], POSIX_SCRIPT[i][8]);
		write_dialect(DIALECT_WINDOWS);
		for (i = 0; i < $size(WIN_SCRIPT); i++)
			send_item(WIN_SCRIPT[i][7:0], WIN_SCRIPT[i][8]);

		// Random phases, alternating dialect. Lines run across phase boundaries, so
		// dialect changes also hit open arguments, quotes and held backslashes.
		for (ph = 0; ph < PHASES; ph++) begin
			write_dialect((ph % 2 == 0) ? DIALECT_POSIX : DIALECT_WINDOWS);
			// last phase runs at full rate on both sides
			idle_on = (ph < PHASES - 1);
			if (ph == 1)
				hold_off_req = 1'b1;
			for (i = 0; i < ITEMS_PER_PHASE; i++)
				send_random();
		end

		wait_idle();
		if (tokens_pending != 0)
			$display("ERROR: %0d results never arrived", tokens_pending);
		if (fail_count == 0 && tokens_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
